### rtl/core/assert_macros.svh
// Assertion macros shared by the neighbour search RTL.
// Included by the modules that carry concurrent checks; needs clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that holds on every edge out of reset
`define CPNS_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Same-cycle implication
`define CPNS_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define CPNS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/cpns_pkg.sv
// Shared types, constants and helpers of the neighbour search block.
// No dependencies; imported by every module of the block but cpns_ram.
package cpns_pkg;

   localparam int MAX_PARTICLES = 64;
   localparam int DIMENSIONS    = 3;
   localparam int IDX_W   = $clog2(MAX_PARTICLES);
   localparam int CNT_W   = $clog2(MAX_PARTICLES + 1);
   localparam int COORD_W = 31;
   localparam int LEN_W   = 30;
   localparam int SCALE_W = 16;
   localparam int HITS_W  = 16;
   localparam int DIFF_W  = 32;
   localparam int MAG_W   = 31;
   localparam int SQ_W    = 2 * MAG_W;
   localparam int RSQ_W   = 64;
   localparam int DIST_W  = 32;
   localparam int HS_W    = LEN_W + SCALE_W;
   localparam int HALF_W  = HS_W / 2;
   localparam int PP_W    = 2 * HALF_W;
   localparam int LIM_W   = 2 * HS_W;
   localparam int RSQ_SH  = 24;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_W     = 16;
   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 144;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SEARCH_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MAX_INTER   = 1'b1;
   localparam logic [HITS_W-1:0]    MAX_INTER_RESET = 16'd64;

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_ADD   = 2'd1,
      ACT_QUERY = 2'd2
   } action_type;

   typedef struct packed {
      logic [SCALE_W-1:0]        scale;
      logic [LEN_W-1:0]          length;
      logic signed [COORD_W-1:0] z;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } particle_type;

   typedef struct packed {
      logic [2:0]                pad;
      logic [SCALE_W-1:0]        scale_factor;
      logic [LEN_W-1:0]          smoothing_length;
      logic signed [COORD_W-1:0] pos_z;
      logic signed [COORD_W-1:0] pos_y;
      logic signed [COORD_W-1:0] pos_x;
      logic [1:0]                action;
   } req_type;

   typedef struct packed {
      logic [1:0]               pad;
      logic                     count_overflow;
      logic signed [DIFF_W-1:0] diff_z;
      logic signed [DIFF_W-1:0] diff_y;
      logic signed [DIFF_W-1:0] diff_x;
      logic [DIST_W-1:0]        distance;
      logic [IDX_W-1:0]         second_index;
      logic [IDX_W-1:0]         first_index;
      logic                     found;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SCAN, ST_READ, ST_LOAD, ST_MULT, ST_SUM, ST_LIMIT,
      ST_CMP, ST_ROOT, ST_EMIT, ST_NEXT, ST_FLUSH, ST_STORE
   } state_type;

   typedef struct packed {
      logic latch;
      logic clear;
      logic sqrt_start;
      logic emit;
      logic next;
      logic flush;
      logic store;
      logic qinc;
   } cmd_type;

   typedef struct packed {
      logic store_full;
      logic query_full;
      logic scan_done;
      logic hit;
      logic sqrt_busy;
      logic emit_ready;
      logic out_free;
   } status_type;

   // saturating hit counter increment
   function automatic logic [HITS_W-1:0] sat_inc(input logic [HITS_W-1:0] c);
      return (&c) ? c : c + 1'b1;
   endfunction

endpackage

### rtl/core/cutoff_pair_neighbour_search.sv
// Top level of the cutoff pair neighbour search: configuration registers and wiring.
// Depends on cpns_pkg, cpns_ctrl and cpns_datapath.
//
//   channel  | dir | handshake             | content
//   req_*    | in  | req_tvalid/req_tready | action, position, smoothing length, scale
//   rsp_*    | out | rsp_tvalid/rsp_tready | one word per interacting pair (a zero word if none), tlast on final
//   csr_*    | in  | csr_we                | search_mode (0), max_interactions (1)
//
// A self-mode add or a query walks every stored particle through the scan, read, load,
// multiply, sum, limit, compare and next states, on a hit also waiting on the 32-step
// square root and emitting; then come an end-of-walk check, a flush and, for a self-mode
// add, a store. Clear and ignored words are handled in idle; cross-mode adds just store.
// Synchronous active-high reset; the particle store needs no clearing pass.
// A stalled result side holds the walk at the next hit; req_tready is high only when idle.
module cutoff_pair_neighbour_search
   import cpns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // action, pos_x, pos_y, pos_z, smoothing_length, scale_factor, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // found, first_index, second_index, distance, diff_x, diff_y, diff_z,
   // count_overflow, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   logic              search_mode_ff;
   logic [HITS_W-1:0] max_inter_ff;
   cmd_type           cmd;
   status_type        status;
   req_type           req_data;
   rsp_type           rsp_data;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         search_mode_ff <= 1'b0;
         max_inter_ff   <= MAX_INTER_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SEARCH_MODE: search_mode_ff <= csr_wdata[0];
            REG_MAX_INTER:   max_inter_ff   <= csr_wdata[HITS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign req_data  = req_type'(req_tdata);
   assign rsp_tdata = RSP_DATA_W'(rsp_data);

   cpns_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_action  (req_data.action),
      .search_mode (search_mode_ff),
      .status      (status),
      .req_tready  (req_tready),
      .cmd         (cmd)
   );

   cpns_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_data         (req_data),
      .search_mode      (search_mode_ff),
      .max_interactions (max_inter_ff),
      .rsp_tready       (rsp_tready),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_data         (rsp_data),
      .rsp_last         (rsp_tlast)
   );

endmodule

### rtl/core/cpns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cpns_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/cpns_sqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on cpns_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cpns_sqrt
   import cpns_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [RSQ_W-1:0]  radicand,
   output logic              busy,
   output logic [DIST_W-1:0] root
);

   localparam int STEP_W = $clog2(DIST_W);
   localparam int REM_W  = DIST_W + 2;

   logic              busy_ff, busy_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [RSQ_W-1:0]  rad_ff, rad_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [DIST_W-1:0] root_ff, root_in;
   logic [REM_W+1:0]  rem_try, trial;

   // one digit step
   always_comb begin
      rem_try = {rem_ff, rad_ff[RSQ_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      busy_in = busy_ff;
      step_in = step_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in = {rad_ff[RSQ_W-3:0], 2'b00};
         if (rem_try >= trial) begin
            rem_in  = REM_W'(rem_try - trial);
            root_in = {root_ff[DIST_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(rem_try);
            root_in = {root_ff[DIST_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (&step_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign busy = busy_ff;
   assign root = root_ff;

   `CPNS_ASSERT_NEXT(a_sqrt_runs, start, busy_ff, "square root did not start")

endmodule

### rtl/core/cpns_datapath.sv
// Datapath: particle store, hit counts, distance pipeline, result buffer.
// Depends on cpns_pkg, cpns_ram, cpns_sqrt and assert_macros.svh.
`include "assert_macros.svh"
module cpns_datapath
   import cpns_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  req_type               req_data,
   input  logic                  search_mode,
   input  logic [HITS_W-1:0]     max_interactions,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output rsp_type               rsp_data,
   output logic                  rsp_last
);

   // item and loop bookkeeping
   req_type                  req_ff;
   logic [IDX_W-1:0]         me_ff;
   logic [CNT_W-1:0]         j_ff;
   logic [CNT_W-1:0]         stored_count_ff;
   logic [CNT_W-1:0]         query_count_ff;
   logic [MAX_PARTICLES-1:0] hits_valid_ff;
   logic [HITS_W-1:0]        me_hits_ff;
   logic [IDX_W-1:0]         j_idx;

   // pipeline registers
   logic signed [DIFF_W-1:0] dx_ff, dy_ff, dz_ff;
   logic [LEN_W-1:0]         h_ff;
   logic [SCALE_W-1:0]       s_ff;
   logic [HITS_W-1:0]        j_hits_ff;
   logic [SQ_W-1:0]          sqx_ff, sqy_ff, sqz_ff;
   logic [HS_W-1:0]          hs_ff;
   logic [RSQ_W-1:0]         rsq_ff, rsq2_ff;
   logic [PP_W-1:0]          aa_ff, ab_ff, bb_ff;
   logic [LIM_W-1:0]         lim_ff;

   // result buffer and output register
   rsp_type held_ff;
   logic    held_valid_ff;
   rsp_type out_ff;
   logic    out_last_ff;
   logic    out_valid_ff;

   particle_type store_rd, cur_p, pa, pb;
   logic [HITS_W-1:0] hits_rd, hits_wr;
   logic              hits_we;
   logic [IDX_W-1:0]  hits_addr;
   logic [DIST_W-1:0] root;
   logic              sqrt_busy;
   logic signed [DIFF_W-1:0] dx_in, dy_in, dz_in;
   logic [DIFF_W-1:0] mx, my, mz;
   logic [HITS_W-1:0] j_hits_new, me_hits_new;
   logic              out_free, push;
   rsp_type           hit_rsp, zero_rsp;

   assign j_idx = j_ff[IDX_W-1:0];
   assign cur_p = '{scale: req_ff.scale_factor, length: req_ff.smoothing_length,
                    z: req_ff.pos_z, y: req_ff.pos_y, x: req_ff.pos_x};

   cpns_ram #(.WIDTH($bits(particle_type)), .DEPTH(MAX_PARTICLES)) u_store (
      .clock   (clock),
      .wr_en   (cmd.store),
      .wr_addr (me_ff),
      .wr_data (cur_p),
      .rd_addr (j_idx),
      .rd_data (store_rd)
   );

   // hits written at j on a hit, at the new particle when it is stored in self mode
   assign hits_we   = cmd.emit || (cmd.store && !search_mode);
   assign hits_addr = cmd.emit ? j_idx : me_ff;
   assign hits_wr   = cmd.emit ? j_hits_new : me_hits_ff;

   cpns_ram #(.WIDTH(HITS_W), .DEPTH(MAX_PARTICLES)) u_hits (
      .clock   (clock),
      .wr_en   (hits_we),
      .wr_addr (hits_addr),
      .wr_data (hits_wr),
      .rd_addr (j_idx),
      .rd_data (hits_rd)
   );

   cpns_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.sqrt_start),
      .radicand (rsq2_ff),
      .busy     (sqrt_busy),
      .root     (root)
   );

   // stage 1: first minus second particle, larger support
   always_comb begin
      pa = search_mode ? cur_p : store_rd;
      pb = search_mode ? store_rd : cur_p;
      dx_in = {pa.x[COORD_W-1], pa.x} - {pb.x[COORD_W-1], pb.x};
      dy_in = (DIMENSIONS >= 2) ? {pa.y[COORD_W-1], pa.y} - {pb.y[COORD_W-1], pb.y} : '0;
      dz_in = (DIMENSIONS >= 3) ? {pa.z[COORD_W-1], pa.z} - {pb.z[COORD_W-1], pb.z} : '0;
   end

   assign mx = dx_ff[DIFF_W-1] ? -dx_ff : dx_ff;
   assign my = dy_ff[DIFF_W-1] ? -dy_ff : dy_ff;
   assign mz = dz_ff[DIFF_W-1] ? -dz_ff : dz_ff;

   always_ff @(posedge clock) begin
      dx_ff     <= dx_in;
      dy_ff     <= dy_in;
      dz_ff     <= dz_in;
      h_ff      <= (pa.length > pb.length) ? pa.length : pb.length;
      s_ff      <= (pa.scale > pb.scale) ? pa.scale : pb.scale;
      j_hits_ff <= hits_valid_ff[j_idx] ? hits_rd : '0;
      // stage 2: squares and limit product
      sqx_ff <= mx[MAG_W-1:0] * mx[MAG_W-1:0];
      sqy_ff <= my[MAG_W-1:0] * my[MAG_W-1:0];
      sqz_ff <= mz[MAG_W-1:0] * mz[MAG_W-1:0];
      hs_ff  <= h_ff * s_ff;
      // stage 3: squared distance, partial products of the limit square
      rsq_ff <= RSQ_W'(sqx_ff) + RSQ_W'(sqy_ff) + RSQ_W'(sqz_ff);
      aa_ff  <= hs_ff[HS_W-1:HALF_W] * hs_ff[HS_W-1:HALF_W];
      ab_ff  <= hs_ff[HS_W-1:HALF_W] * hs_ff[HALF_W-1:0];
      bb_ff  <= hs_ff[HALF_W-1:0] * hs_ff[HALF_W-1:0];
      // stage 4: limit square
      rsq2_ff <= rsq_ff;
      lim_ff  <= {aa_ff, {(2*HALF_W){1'b0}}} + {{(HALF_W-1){1'b0}}, ab_ff, {(HALF_W+1){1'b0}}}
                 + LIM_W'(bb_ff);
   end

   // hit result
   assign j_hits_new  = sat_inc(j_hits_ff);
   assign me_hits_new = sat_inc(me_hits_ff);

   always_comb begin
      hit_rsp                = '0;
      hit_rsp.found          = 1'b1;
      hit_rsp.first_index    = search_mode ? me_ff : j_idx;
      hit_rsp.second_index   = search_mode ? j_idx : me_ff;
      hit_rsp.distance       = root;
      hit_rsp.diff_x         = dx_ff;
      hit_rsp.diff_y         = dy_ff;
      hit_rsp.diff_z         = dz_ff;
      hit_rsp.count_overflow = (me_hits_new >= max_interactions) ||
                               (j_hits_new >= max_interactions);
      zero_rsp               = '0;
   end

   assign out_free = !out_valid_ff || rsp_tready;
   assign push     = (cmd.emit && held_valid_ff) || cmd.flush;

   // counters and valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         stored_count_ff <= '0;
         query_count_ff  <= '0;
         hits_valid_ff   <= '0;
         held_valid_ff   <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         if (cmd.clear) begin
            stored_count_ff <= '0;
            query_count_ff  <= '0;
            hits_valid_ff   <= '0;
         end
         if (cmd.emit) begin
            hits_valid_ff[j_idx] <= 1'b1;
            held_valid_ff        <= 1'b1;
         end
         if (cmd.flush) begin
            held_valid_ff <= 1'b0;
         end
         if (cmd.store) begin
            stored_count_ff <= stored_count_ff + 1'b1;
            if (!search_mode) begin
               hits_valid_ff[me_ff] <= 1'b1;
            end
         end
         if (cmd.qinc) begin
            query_count_ff <= query_count_ff + 1'b1;
         end
         if (push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         req_ff     <= req_data;
         me_ff      <= (action_type'(req_data.action) == ACT_ADD) ?
                       stored_count_ff[IDX_W-1:0] : query_count_ff[IDX_W-1:0];
         j_ff       <= '0;
         me_hits_ff <= '0;
      end else if (cmd.next) begin
         j_ff <= j_ff + 1'b1;
      end
      if (cmd.emit) begin
         me_hits_ff <= me_hits_new;
         held_ff    <= hit_rsp;
      end
      if (push) begin
         out_ff      <= cmd.flush ? (held_valid_ff ? held_ff : zero_rsp) : held_ff;
         out_last_ff <= cmd.flush;
      end
   end

   assign status = '{
      store_full: (stored_count_ff == CNT_W'(MAX_PARTICLES)),
      query_full: (query_count_ff == CNT_W'(MAX_PARTICLES)),
      scan_done:  (j_ff == stored_count_ff),
      hit:        ({{(LIM_W-RSQ_W-RSQ_SH){1'b0}}, rsq2_ff, {RSQ_SH{1'b0}}} < lim_ff),
      sqrt_busy:  sqrt_busy,
      emit_ready: (!held_valid_ff || out_free),
      out_free:   out_free
   };

   assign rsp_tvalid = out_valid_ff;
   assign rsp_data   = out_ff;
   assign rsp_last   = out_last_ff;

   `CPNS_ASSERT_IMPL(a_no_overwrite, push, out_free, "result pushed over a waiting word")
   `CPNS_ASSERT(a_count_range, (stored_count_ff <= CNT_W'(MAX_PARTICLES)) && (query_count_ff <= CNT_W'(MAX_PARTICLES)), "particle count beyond store depth")

endmodule

### rtl/core/cpns_ctrl.sv
// Sequencer: accepts words, walks the store one entry at a time, drives the datapath.
// Depends on cpns_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cpns_ctrl
   import cpns_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic [1:0] req_action,
   input  logic       search_mode,
   input  status_type status,
   output logic       req_tready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      is_add_ff, is_add_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         is_add_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         is_add_ff <= is_add_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      is_add_in  = is_add_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (action_type'(req_action))
                  ACT_CLEAR: begin
                     cmd.clear = 1'b1;
                  end
                  ACT_ADD: begin
                     if (!status.store_full) begin
                        cmd.latch = 1'b1;
                        is_add_in = 1'b1;
                        state_in  = search_mode ? ST_STORE : ST_SCAN;
                     end
                  end
                  ACT_QUERY: begin
                     if (search_mode && !status.query_full) begin
                        cmd.latch = 1'b1;
                        is_add_in = 1'b0;
                        state_in  = ST_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN:  state_in = status.scan_done ? ST_FLUSH : ST_READ;
         ST_READ:  state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_MULT;
         ST_MULT:  state_in = ST_SUM;
         ST_SUM:   state_in = ST_LIMIT;
         ST_LIMIT: state_in = ST_CMP;
         ST_CMP: begin
            if (status.hit) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_ROOT;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_ROOT: begin
            if (!status.sqrt_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (status.emit_ready) begin
               cmd.emit = 1'b1;
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.next = 1'b1;
            state_in = ST_SCAN;
         end
         ST_FLUSH: begin
            if (status.out_free) begin
               cmd.flush = 1'b1;
               cmd.qinc  = !is_add_ff;
               state_in  = is_add_ff ? ST_STORE : ST_IDLE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   `CPNS_ASSERT_NEXT(a_root_follows_start, cmd.sqrt_start, state_ff == ST_ROOT, "root wait skipped")
   `CPNS_ASSERT_NEXT(a_latch_leaves_idle, cmd.latch, state_ff != ST_IDLE, "latched word not processed")

endmodule
